// ===== rtl/core/rti_pkg.sv =====
`timescale 1ns / 1ps

package rti_pkg;

    localparam int NUM_REGS = 6;

    localparam int REG_ORIGIN_X = 0;
    localparam int REG_ORIGIN_Y = 1;
    localparam int REG_ORIGIN_Z = 2;
    localparam int REG_DIR_X    = 3;
    localparam int REG_DIR_Y    = 4;
    localparam int REG_DIR_Z    = 5;

    localparam int FIFO_DEPTH   = 4;

    typedef logic [2:0] t_reg_idx;

endpackage

// ===== rtl/core/ray_triangle_intersect.sv =====
`timescale 1ns / 1ps

// Moller-Trumbore ray/triangle test in exact signed fixed point. The ray
// origin and direction sit in six APB registers (the user must write them
// only while the block is idle; the block does not enforce this). Each input
// transaction carries one triangle and yields one result transaction with a
// hit flag and a saturated unsigned Q15.16 distance. One triangle is accepted
// per cycle while the pipeline is not stalled. A result passes through an
// 8-stage geometry pipeline (edges, cross products, split dot products, sign
// fold, range checks), the 4-entry queue, a CW-stage restoring divider (an
// overflow check, then one quotient bit per stage), then the output register.
// Either side may stall; the queue absorbs short output stalls.
module ray_triangle_intersect
    import rti_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [$clog2(NUM_REGS*((COORD_WIDTH > 32) ? 8 : 4))-1:0] paddr,
    input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                   pready,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_WIDTH-1:0] i_first_x,
    input  logic [COORD_WIDTH-1:0] i_first_y,
    input  logic [COORD_WIDTH-1:0] i_first_z,
    input  logic [COORD_WIDTH-1:0] i_second_x,
    input  logic [COORD_WIDTH-1:0] i_second_y,
    input  logic [COORD_WIDTH-1:0] i_second_z,
    input  logic [COORD_WIDTH-1:0] i_third_x,
    input  logic [COORD_WIDTH-1:0] i_third_y,
    input  logic [COORD_WIDTH-1:0] i_third_z,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_hit,
    output logic [COORD_WIDTH-2:0] o_distance
);

    localparam int CW     = COORD_WIDTH;
    localparam int DW     = (CW > 32) ? 64 : 32;
    localparam int STRIDE = (CW > 32) ? 8 : 4;
    localparam int AW     = $clog2(NUM_REGS*STRIDE);
    localparam int SH     = $clog2(STRIDE);
    localparam int SW     = 3*CW + 6;
    localparam int QDW    = 2*SW + 1;

    logic [CW-1:0]  r_org [3];
    logic [CW-1:0]  r_dir [3];
    logic [CW-1:0]  w_vtx [9];
    logic [AW-SH-1:0] w_idx;
    logic           w_wr;
    logic [CW-1:0]  w_rd;

    logic           w_f_vld, w_f_rdy, w_f_cand;
    logic [SW-1:0]  w_f_det, w_f_tn;
    logic           w_q_vld, w_q_rdy;
    logic [QDW-1:0] w_q_data;

    assign pready = 1'b1;
    assign w_idx  = paddr[AW-1:SH];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_org[i] <= '0;
                r_dir[i] <= '0;
            end
        end else if (w_wr) begin
            unique case (w_idx)
                (AW-SH)'(REG_ORIGIN_X): r_org[0] <= pwdata[CW-1:0];
                (AW-SH)'(REG_ORIGIN_Y): r_org[1] <= pwdata[CW-1:0];
                (AW-SH)'(REG_ORIGIN_Z): r_org[2] <= pwdata[CW-1:0];
                (AW-SH)'(REG_DIR_X):    r_dir[0] <= pwdata[CW-1:0];
                (AW-SH)'(REG_DIR_Y):    r_dir[1] <= pwdata[CW-1:0];
                (AW-SH)'(REG_DIR_Z):    r_dir[2] <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            (AW-SH)'(REG_ORIGIN_X): w_rd = r_org[0];
            (AW-SH)'(REG_ORIGIN_Y): w_rd = r_org[1];
            (AW-SH)'(REG_ORIGIN_Z): w_rd = r_org[2];
            (AW-SH)'(REG_DIR_X):    w_rd = r_dir[0];
            (AW-SH)'(REG_DIR_Y):    w_rd = r_dir[1];
            (AW-SH)'(REG_DIR_Z):    w_rd = r_dir[2];
            default:                w_rd = '0;
        endcase
    end

    assign prdata = DW'(w_rd);

    assign w_vtx[0] = i_first_x;
    assign w_vtx[1] = i_first_y;
    assign w_vtx[2] = i_first_z;
    assign w_vtx[3] = i_second_x;
    assign w_vtx[4] = i_second_y;
    assign w_vtx[5] = i_second_z;
    assign w_vtx[6] = i_third_x;
    assign w_vtx[7] = i_third_y;
    assign w_vtx[8] = i_third_z;

    rti_front #(.CW(CW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_vtx   (w_vtx),
        .i_org   (r_org),
        .i_dir   (r_dir),
        .o_valid (w_f_vld),
        .i_ready (w_f_rdy),
        .o_cand  (w_f_cand),
        .o_det   (w_f_det),
        .o_tn    (w_f_tn)
    );

    rti_fifo #(.WIDTH(QDW), .DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_vld),
        .o_ready (w_f_rdy),
        .i_data  ({w_f_cand, w_f_det, w_f_tn}),
        .o_valid (w_q_vld),
        .i_ready (w_q_rdy),
        .o_data  (w_q_data)
    );

    rti_back #(.CW(CW), .FB(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_vld),
        .o_ready (w_q_rdy),
        .i_cand  (w_q_data[QDW-1]),
        .i_det   (w_q_data[2*SW-1:SW]),
        .i_tn    (w_q_data[SW-1:0]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hit   (o_hit),
        .o_dist  (o_distance)
    );

endmodule

// ===== rtl/core/rti_front.sv =====
`timescale 1ns / 1ps

module rti_front #(
    parameter int CW = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [CW-1:0]           i_vtx [9],
    input  logic [CW-1:0]           i_org [3],
    input  logic [CW-1:0]           i_dir [3],
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_cand,
    output logic [3*CW+5:0]         o_det,
    output logic [3*CW+5:0]         o_tn
);

    localparam int E  = CW + 1;
    localparam int PW = 2*CW + 2;
    localparam int QW = 2*CW + 3;
    localparam int L  = CW + 1;
    localparam int MW = 2*CW + 3;
    localparam int SW = 3*CW + 6;
    localparam int NS = 8;

    logic [NS-1:0] r_vld;
    logic          w_adv;

    logic signed [CW-1:0]   w_d   [3];
    logic signed [E-1:0]    r1_e1 [3];
    logic signed [E-1:0]    r1_e2 [3];
    logic signed [E-1:0]    r1_t  [3];
    logic signed [2*CW:0]   r2_pp [6];
    logic signed [2*CW+1:0] r2_qp [6];
    logic signed [E-1:0]    r2_e1 [3];
    logic signed [E-1:0]    r2_e2 [3];
    logic signed [E-1:0]    r2_t  [3];
    logic signed [PW-1:0]   r3_p  [3];
    logic signed [QW-1:0]   r3_q  [3];
    logic signed [E-1:0]    r3_e1 [3];
    logic signed [E-1:0]    r3_e2 [3];
    logic signed [E-1:0]    r3_t  [3];
    logic signed [MW-1:0]   r4_lo [12];
    logic signed [MW-1:0]   r4_hi [12];
    logic signed [SW-1:0]   r5_m  [12];
    logic signed [SW-1:0]   r6_s  [4];
    logic signed [SW-1:0]   r7_det, r7_un, r7_vn, r7_tn;
    logic                   r7_nz;
    logic signed [SW-1:0]   w_du;
    logic signed [SW:0]     w_duv;
    logic                   r8_cand;
    logic [SW-1:0]          r8_det, r8_tn;

    assign w_adv   = !r_vld[NS-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[NS-1];
    assign o_cand  = r8_cand;
    assign o_det   = r8_det;
    assign o_tn    = r8_tn;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = $signed(i_dir[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // edges and origin offset, cross product terms and their differences
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_e1[i] <= $signed({i_vtx[3+i][CW-1], i_vtx[3+i]})
                          - $signed({i_vtx[i][CW-1], i_vtx[i]});
                r1_e2[i] <= $signed({i_vtx[6+i][CW-1], i_vtx[6+i]})
                          - $signed({i_vtx[i][CW-1], i_vtx[i]});
                r1_t[i]  <= $signed({i_org[i][CW-1], i_org[i]})
                          - $signed({i_vtx[i][CW-1], i_vtx[i]});
            end
            for (int i = 0; i < 3; i++) begin
                r2_pp[2*i]   <= w_d[(i+1)%3] * r1_e2[(i+2)%3];
                r2_pp[2*i+1] <= w_d[(i+2)%3] * r1_e2[(i+1)%3];
                r2_qp[2*i]   <= r1_t[(i+1)%3] * r1_e1[(i+2)%3];
                r2_qp[2*i+1] <= r1_t[(i+2)%3] * r1_e1[(i+1)%3];
                r2_e1[i]     <= r1_e1[i];
                r2_e2[i]     <= r1_e2[i];
                r2_t[i]      <= r1_t[i];
            end
            for (int i = 0; i < 3; i++) begin
                r3_p[i]  <= PW'(r2_pp[2*i]) - PW'(r2_pp[2*i+1]);
                r3_q[i]  <= QW'(r2_qp[2*i]) - QW'(r2_qp[2*i+1]);
                r3_e1[i] <= r2_e1[i];
                r3_e2[i] <= r2_e2[i];
                r3_t[i]  <= r2_t[i];
            end
        end
    end

    // dot products: split the wide operand into low and high halves
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r4_lo[i]   <= r3_e1[i] * $signed({1'b0, r3_p[i][L-1:0]});
                r4_hi[i]   <= r3_e1[i] * $signed(r3_p[i][PW-1:L]);
                r4_lo[3+i] <= r3_t[i]  * $signed({1'b0, r3_p[i][L-1:0]});
                r4_hi[3+i] <= r3_t[i]  * $signed(r3_p[i][PW-1:L]);
                r4_lo[6+i] <= w_d[i]   * $signed({1'b0, r3_q[i][L-1:0]});
                r4_hi[6+i] <= w_d[i]   * $signed(r3_q[i][QW-1:L]);
                r4_lo[9+i] <= r3_e2[i] * $signed({1'b0, r3_q[i][L-1:0]});
                r4_hi[9+i] <= r3_e2[i] * $signed(r3_q[i][QW-1:L]);
            end
            for (int j = 0; j < 12; j++) begin
                r5_m[j] <= (SW'(r4_hi[j]) <<< L) + SW'(r4_lo[j]);
            end
            for (int k = 0; k < 4; k++) begin
                r6_s[k] <= r5_m[3*k] + r5_m[3*k+1] + r5_m[3*k+2];
            end
        end
    end

    assign w_du  = r7_det - r7_un;
    assign w_duv = SW'(r7_det) - (SW+1)'(r7_un) - (SW+1)'(r7_vn);

    // fold the determinant sign, then range checks
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_nz  <= r6_s[0] != '0;
            r7_det <= r6_s[0][SW-1] ? -r6_s[0] : r6_s[0];
            r7_un  <= r6_s[0][SW-1] ? -r6_s[1] : r6_s[1];
            r7_vn  <= r6_s[0][SW-1] ? -r6_s[2] : r6_s[2];
            r7_tn  <= r6_s[0][SW-1] ? -r6_s[3] : r6_s[3];
            r8_cand <= r7_nz && !r7_un[SW-1] && !w_du[SW-1] && !r7_vn[SW-1]
                    && !w_duv[SW] && !r7_tn[SW-1];
            r8_det  <= r7_det;
            r8_tn   <= r7_tn;
        end
    end

endmodule

// ===== rtl/core/rti_fifo.sv =====
`timescale 1ns / 1ps

module rti_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0]   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wp, r_rp;
    logic [PTR_W:0]     r_cnt;
    logic               w_push, w_pop;

    assign o_ready = r_cnt != (PTR_W+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PTR_W+1)'(w_push) - (PTR_W+1)'(w_pop);
        end
    end

endmodule

// ===== rtl/core/rti_back.sv =====
`timescale 1ns / 1ps

module rti_back #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_cand,
    input  logic [3*CW+5:0]  i_det,
    input  logic [3*CW+5:0]  i_tn,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_hit,
    output logic [CW-2:0]    o_dist
);

    localparam int SW = 3*CW + 6;
    localparam int RW = SW + FB + CW;

    logic [CW-1:0]  r_bv;
    logic [RW-1:0]  r_br [CW];
    logic [SW-1:0]  r_bd [CW];
    logic [CW-2:0]  r_bq [CW];
    logic           r_bc [CW];
    logic           r_bs [CW];
    logic           r_ov, r_hit;
    logic [CW-2:0]  r_dist;
    logic           w_adv, w_hit;
    logic [RW-1:0]  w_num;

    assign w_adv   = !r_ov || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_ov;
    assign o_hit   = r_hit;
    assign o_dist  = r_dist;
    assign w_num   = RW'(i_tn) << FB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_bv <= {r_bv[CW-2:0], i_valid};
            r_ov <= r_bv[CW-1];
        end
    end

    // entry: overflow check against det << (CW-1)
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_br[0] <= w_num;
            r_bd[0] <= i_det;
            r_bq[0] <= '0;
            r_bc[0] <= i_cand;
            r_bs[0] <= w_num >= (RW'(i_det) << (CW-1));
        end
    end

    // one quotient bit per stage
    for (genvar j = 1; j < CW; j++) begin : g_div
        localparam int K = CW - 1 - j;
        logic [RW:0] w_diff;
        assign w_diff = {1'b0, r_br[j-1]} - ((RW+1)'(r_bd[j-1]) << K);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_br[j] <= w_diff[RW] ? r_br[j-1] : w_diff[RW-1:0];
                r_bq[j] <= r_bq[j-1] | ((CW-1)'(!w_diff[RW]) << K);
                r_bd[j] <= r_bd[j-1];
                r_bc[j] <= r_bc[j-1];
                r_bs[j] <= r_bs[j-1];
            end
        end
    end

    assign w_hit = r_bc[CW-1] && (r_bs[CW-1] || r_bq[CW-1] != '0);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hit  <= w_hit;
            r_dist <= !w_hit ? '0 : (r_bs[CW-1] ? '1 : r_bq[CW-1]);
        end
    end

endmodule
